### rtl/bpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_pkg: shared definitions for the bitmap page-frame allocator
// Default geometry, command and status codes, and the bitmap RAM control
// group.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   // Default geometry. All three must be powers of two.
   localparam int NUM_BLOCKS_DEF  = 4096;
   localparam int WORD_BITS_DEF   = 32;
   localparam int BLOCK_BYTES_DEF = 4096;

   // Field widths of the stream words
   localparam int CMD_W    = 3;
   localparam int BASE_W   = 32;
   localparam int LEN_W    = 32;
   localparam int QIDX_W   = 12;
   localparam int STATUS_W = 2;
   localparam int BADDR_W  = 24;
   localparam int FREE_W   = 13;
   localparam int KB_W     = 15;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;

   localparam logic [KB_W-1:0] MEM_KB_RESET = 15'd16384;

   // Commands
   localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

   // Result status
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd2;

   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } map_ctl_type;

endpackage

### rtl/bpfa_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_map_ram: usage bitmap storage
// One write and one registered read port per cycle. A per-word valid bit
// makes an unwritten or cleared word read as all ones (every block used).
// ----------------------------------------------------------------------------
module bpfa_map_ram
   import bpfa_pkg::*;
#(
   parameter int WORDS     = NUM_BLOCKS_DEF / WORD_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  map_ctl_type          ctl,
   input  logic [AW-1:0]        rd_addr,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [0:WORDS-1];
   logic [WORD_BITS-1:0] rd_q_ff;
   logic [WORDS-1:0]     vld_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // Valid bits: reset and init drop them all at once
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (ctl.clear_all) begin
            vld_ff <= '0;
         end else if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '1;

endmodule

### rtl/bitmap_page_frame_allocator_top.sv
`timescale 1ns / 1ps
// Steps: init and unknown commands go straight to done; query walks and finishes;
//   range runs setup, span, walk, finish; allocate setup, walk, finish. A walk reads
//   one word per cycle, at most NUM_BLOCKS/WORD_BITS, and writes it back for a range.
// Throughput: one command at a time; the next is taken once the result sits in the
//   output register, and a result still waiting holds the next one at its done step.
// Reset: synchronous; all blocks marked used, count = NUM_BLOCKS, 16384 KB.
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top: bitmap physical page-frame allocator
// A small sequencer walks a used/free bitmap one word per cycle through a
// shared mask/search unit, and keeps a saturating count of blocks in use.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_top
   import bpfa_pkg::*;
#(
   parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
   parameter int WORD_BITS   = WORD_BITS_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: tuser = cmd[2:0]
   // tdata  = start_addr[31:0], length_bytes[63:32], block_index[75:64], zero[79:76]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   // response: tdata = status[1:0], frame_addr[25:2], block_used[26],
   //                   free_blocks[39:27]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // memory_size_kb register
   input  logic                  csr_wr_en,
   input  logic [KB_W-1:0]       csr_wr_data
);

   localparam int BBLOG2    = $clog2(BLOCK_BYTES);
   localparam int WBLOG2    = $clog2(WORD_BITS);
   localparam int BLK_W     = $clog2(NUM_BLOCKS);
   localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
   localparam int MAP_WORDS = NUM_BLOCKS / WORD_BITS;
   localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int ACC_W     = KB_W + 10;

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RSETUP = 3'd1;
   localparam logic [2:0] S_RSPAN  = 3'd2;
   localparam logic [2:0] S_ASETUP = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   // Request fields
   logic [CMD_W-1:0]  req_cmd;
   logic [BASE_W-1:0] req_base;
   logic [LEN_W-1:0]  req_len;
   logic [QIDX_W-1:0] req_idx;

   assign req_cmd  = req_tuser;
   assign req_base = req_tdata[31:0];
   assign req_len  = req_tdata[63:32];
   assign req_idx  = req_tdata[75:64];

   // Registers
   logic [2:0]          state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [LEN_W-1:0]    len_m1_ff, len_m1_in;
   logic [BLK_W-1:0]    first_ff, first_in;
   logic [BLK_W-1:0]    last_ff, last_in;
   logic                first_hi_ff, first_hi_in;
   logic [CNT_W-1:0]    span_ff, span_in;
   logic [WIDX_W-1:0]   rd_word_ff, rd_word_in;
   logic [WIDX_W-1:0]   end_word_ff, end_word_in;
   logic [WIDX_W-1:0]   q_word_ff, q_word_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                issue_done_ff, issue_done_in;
   logic                found_ff, found_in;
   logic [CNT_W-1:0]    use_ff, use_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [BADDR_W-1:0]  addr_ff, addr_in;
   logic                used_ff, used_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [KB_W-1:0]     mem_kb_ff, mem_kb_in;

   // Bitmap RAM interface
   map_ctl_type          map_ctl;
   logic [WORD_BITS-1:0] q_data;
   logic [WORD_BITS-1:0] wr_data;

   bpfa_map_ram #(
      .WORDS     (MAP_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .ctl     (map_ctl),
      .rd_addr (rd_word_ff),
      .wr_addr (q_word_ff),
      .wr_data (wr_data),
      .rd_data (q_data)
   );

   // Accessible blocks: KB * 1024 / BLOCK_BYTES, capped at the map size
   logic [ACC_W-1:0] acc_full;
   logic [CNT_W-1:0] acc;
   logic [CNT_W-1:0] free_cnt;
   logic [CNT_W-1:0] alloc_words;

   assign acc_full    = (ACC_W'(mem_kb_ff) << 10) >> BBLOG2;
   assign acc         = (acc_full > ACC_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                        : CNT_W'(acc_full);
   assign free_cnt    = (acc > use_ff) ? (acc - use_ff) : '0;
   assign alloc_words = acc >> WBLOG2;

   // Range extent, computed from the registered base and length - 1
   logic [BASE_W:0]   end_sum;
   logic [BASE_W:0]   last_full;
   logic [BASE_W-1:0] first_full;

   assign end_sum    = {1'b0, base_ff} + {1'b0, len_m1_ff};
   assign last_full  = end_sum >> BBLOG2;
   assign first_full = base_ff >> BBLOG2;

   logic [BLK_W-1:0]  qblk;
   logic [WIDX_W-1:0] qword;
   logic [WIDX_W-1:0] first_word;
   logic [WIDX_W-1:0] last_word;

   assign qblk       = BLK_W'(req_idx);
   assign qword      = WIDX_W'(qblk >> WBLOG2);
   assign first_word = WIDX_W'(first_ff >> WBLOG2);
   assign last_word  = WIDX_W'(last_ff >> WBLOG2);

   // Shared mask unit: bits of the current word covered by the range
   logic [WBLOG2-1:0]    lo_bit, hi_bit;
   logic [WORD_BITS-1:0] range_mask;

   assign lo_bit     = (q_word_ff == first_word) ? first_ff[WBLOG2-1:0] : '0;
   assign hi_bit     = (q_word_ff == end_word_ff) ? last_ff[WBLOG2-1:0]
                                                  : WBLOG2'(WORD_BITS - 1);
   assign range_mask = ({WORD_BITS{1'b1}} << lo_bit)
                     & ({WORD_BITS{1'b1}} >> (WBLOG2'(WORD_BITS - 1) - hi_bit));

   // Shared search unit: isolate the lowest clear bit and encode it
   logic [WORD_BITS-1:0] nq, iso;
   logic [WBLOG2-1:0]    iso_idx;
   logic [BLK_W-1:0]     found_blk;
   logic [BASE_W-1:0]    found_addr;

   assign nq  = ~q_data;
   assign iso = nq & (~nq + WORD_BITS'(1));

   always_comb begin
      iso_idx = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (iso[j]) begin
            iso_idx = iso_idx | WBLOG2'(j);
         end
      end
   end

   assign found_blk  = BLK_W'({q_word_ff, iso_idx});
   assign found_addr = BASE_W'(found_blk) << BBLOG2;

   // Saturating count updates
   logic [CNT_W:0] use_sum;
   assign use_sum = {1'b0, use_ff} + {1'b0, span_ff};

   logic is_range;
   assign is_range = (cmd_ff == CMD_FREE) || (cmd_ff == CMD_RESERVE);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      base_in       = base_ff;
      len_m1_in     = len_m1_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      first_hi_in   = first_hi_ff;
      span_in       = span_ff;
      rd_word_in    = rd_word_ff;
      end_word_in   = end_word_ff;
      q_word_in     = q_word_ff;
      rd_pend_in    = rd_pend_ff;
      issue_done_in = issue_done_ff;
      found_in      = found_ff;
      use_in        = use_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      used_in       = used_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      map_ctl       = '0;
      wr_data       = q_data;

      // drop the result once taken
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in        = req_cmd;
               base_in       = req_base;
               len_m1_in     = req_len - LEN_W'(1);
               status_in     = ST_OK;
               addr_in       = '0;
               used_in       = 1'b0;
               found_in      = 1'b0;
               rd_pend_in    = 1'b0;
               issue_done_in = 1'b0;
               case (req_cmd)
                  CMD_INIT: begin
                     map_ctl.clear_all = 1'b1;
                     use_in            = acc;
                     state_in          = S_DONE;
                  end
                  CMD_FREE, CMD_RESERVE: begin
                     state_in = (req_len == '0) ? S_DONE : S_RSETUP;
                  end
                  CMD_ALLOC: begin
                     state_in = S_ASETUP;
                  end
                  CMD_QUERY: begin
                     if (32'(req_idx) >= 32'(NUM_BLOCKS)) begin
                        status_in = ST_BAD_IDX;
                        state_in  = S_DONE;
                     end else begin
                        first_in    = qblk;
                        rd_word_in  = qword;
                        end_word_in = qword;
                        state_in    = S_WALK;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_RSETUP: begin
            first_hi_in = first_full >= BASE_W'(NUM_BLOCKS);
            first_in    = BLK_W'(first_full);
            last_in     = (last_full > (BASE_W + 1)'(NUM_BLOCKS - 1))
                        ? BLK_W'(NUM_BLOCKS - 1) : BLK_W'(last_full);
            state_in    = S_RSPAN;
         end

         S_RSPAN: begin
            if (first_hi_ff || (first_ff > last_ff)) begin
               state_in = S_DONE;
            end else begin
               span_in     = CNT_W'(last_ff) - CNT_W'(first_ff) + CNT_W'(1);
               rd_word_in  = first_word;
               end_word_in = last_word;
               state_in    = S_WALK;
            end
         end

         S_ASETUP: begin
            if ((acc <= use_ff) || (alloc_words == '0)) begin
               status_in = ST_NO_FREE;
               state_in  = S_DONE;
            end else begin
               rd_word_in  = '0;
               end_word_in = WIDX_W'(alloc_words - CNT_W'(1));
               state_in    = S_WALK;
            end
         end

         S_WALK: begin
            if (rd_pend_ff && (cmd_ff == CMD_ALLOC) && (q_data != '1)) begin
               // claim the lowest free block of this word
               map_ctl.wr_en = 1'b1;
               wr_data       = q_data | iso;
               addr_in       = found_addr[BADDR_W-1:0];
               found_in      = 1'b1;
               state_in      = S_FINISH;
            end else if (rd_pend_ff && (cmd_ff == CMD_QUERY)) begin
               used_in  = q_data[first_ff[WBLOG2-1:0]];
               state_in = S_FINISH;
            end else begin
               if (rd_pend_ff && is_range) begin
                  map_ctl.wr_en = 1'b1;
                  wr_data = (cmd_ff == CMD_RESERVE) ? (q_data | range_mask)
                                                    : (q_data & ~range_mask);
               end
               if (!issue_done_ff) begin
                  // issue the next word read
                  rd_pend_in = 1'b1;
                  q_word_in  = rd_word_ff;
                  if (rd_word_ff == end_word_ff) begin
                     issue_done_in = 1'b1;
                  end else begin
                     rd_word_in = rd_word_ff + WIDX_W'(1);
                  end
               end else begin
                  rd_pend_in = 1'b0;
                  if (!rd_pend_ff) begin
                     if (cmd_ff == CMD_ALLOC) begin
                        status_in = ST_NO_FREE;
                     end
                     state_in = S_FINISH;
                  end
               end
            end
         end

         S_FINISH: begin
            if (cmd_ff == CMD_RESERVE) begin
               use_in = (use_sum > (CNT_W + 1)'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                             : use_sum[CNT_W-1:0];
            end else if (cmd_ff == CMD_FREE) begin
               use_in = (use_ff >= span_ff) ? (use_ff - span_ff) : '0;
            end else if ((cmd_ff == CMD_ALLOC) && found_ff) begin
               if (use_ff < CNT_W'(NUM_BLOCKS)) begin
                  use_in = use_ff + CNT_W'(1);
               end
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {FREE_W'(free_cnt), used_ff, addr_ff, status_ff};
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration register
   always_comb begin
      mem_kb_in = mem_kb_ff;
      if (csr_wr_en) begin
         mem_kb_in = csr_wr_data;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_pend_ff    <= 1'b0;
         issue_done_ff <= 1'b0;
         found_ff      <= 1'b0;
         use_ff        <= CNT_W'(NUM_BLOCKS);
         rsp_tvalid_ff <= 1'b0;
         mem_kb_ff     <= MEM_KB_RESET;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         issue_done_ff <= issue_done_in;
         found_ff      <= found_in;
         use_ff        <= use_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         mem_kb_ff     <= mem_kb_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      base_ff      <= base_in;
      len_m1_ff    <= len_m1_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      first_hi_ff  <= first_hi_in;
      span_ff      <= span_in;
      rd_word_ff   <= rd_word_in;
      end_word_ff  <= end_word_in;
      q_word_ff    <= q_word_in;
      status_ff    <= status_in;
      addr_ff      <= addr_in;
      used_ff      <= used_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Checks
   a_use_bound: assert property (@(posedge clock) disable iff (reset)
      use_ff <= CNT_W'(NUM_BLOCKS))
      else $error("blocks in use exceeds map size");

   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && rd_pend_ff) |-> (q_word_ff <= end_word_ff))
      else $error("bitmap walk ran past its last word");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[1:0] != ST_OK) |-> (rsp_tdata_ff[25:2] == '0))
      else $error("failed command returned a block address");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the done step");

endmodule
